@@ rtl/grid_brush_stamp_isolate_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the brush stamp block
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef GRID_BRUSH_STAMP_ISOLATE_MACROS_SVH
`define GRID_BRUSH_STAMP_ISOLATE_MACROS_SVH

`ifndef SYNTH
`define GBS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define GBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define GBS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define GBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

@@ rtl/gbs_pkg.sv @@
// ---------------------------------------------------------------------------
// gbs_pkg
// Shared types, constants and helpers of the brush stamp block.
// ---------------------------------------------------------------------------
package gbs_pkg;

   localparam int GRID_X = 64;
   localparam int GRID_Y = 64;
   localparam int COL_W  = $clog2(GRID_X);
   localparam int ROW_W  = $clog2(GRID_Y);
   localparam int WORD_W = 2 * GRID_Y;

   localparam logic [1:0] KIND_LIQUID   = 2'd0;
   localparam logic [1:0] KIND_SOLID    = 2'd1;
   localparam logic [1:0] KIND_ABSORBER = 2'd2;
   localparam logic [1:0] KIND_ISOLATED = 2'd3;

   localparam logic [1:0] CSR_RADIUS = 2'd0;
   localparam logic [1:0] CSR_SHAPE  = 2'd1;

   localparam logic OP_STAMP = 1'b0;
   localparam logic OP_READ  = 1'b1;

   typedef struct packed {
      logic       op;
      logic [5:0] x_pos;
      logic [5:0] y_pos;
      logic [1:0] cell_kind;
   } req_type;

   typedef struct packed {
      logic [1:0] read_kind;
      logic       done_res;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic mem_rd;
      logic rd_req;
      logic stamp_h;
      logic stamp_wr;
      logic sweep_sh;
      logic sweep_wr;
      logic cnt_stamp_init;
      logic cnt_sweep_init;
      logic cnt_inc;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic op_read;
      logic last_stamp;
      logic last_sweep;
      logic sweep_ready;
   } sts_type;

   // Column contents after reset: absorber border, liquid interior.
   function automatic logic [WORD_W-1:0] col_reset(input logic [COL_W-1:0] x);
      logic [WORD_W-1:0] w;
      w = '0;
      for (int y = 0; y < GRID_Y; y++) begin
         if (x == '0 || x == COL_W'(GRID_X - 1) || y == 0 || y == GRID_Y - 1) begin
            w[2*y +: 2] = KIND_ABSORBER;
         end else begin
            w[2*y +: 2] = KIND_LIQUID;
         end
      end
      return w;
   endfunction

endpackage

@@ rtl/grid_brush_stamp_isolate.sv @@
// ---------------------------------------------------------------------------
// grid_brush_stamp_isolate
// 64 x 64 cell map: stamp a square or disc brush, then sweep the interior
// marking enclosed cells isolated and unenclosed isolated ones solid; or read one cell.
// ---------------------------------------------------------------------------
//  channel   ports                        handshake
//  request   start, busy, req_data        taken when start && !busy
//  response  rsp_valid, rsp_data          one-cycle strobe, cannot stall
//  control   csr_we, csr_index, csr_wdata write when csr_we, no wait
//
// A read passes the launch and read states before the response strobe. A
// stamp reads and writes each column the clipped brush spans, then sweeps,
// paced by the single-port column memory: one column word per read or
// write, and the sweep reads each column once into a three-column window.
// Reset is synchronous; the map comes back as absorber border and liquid
// interior at once through per-column valid bits (no clearing pass).
// busy drops in the cycle of the response strobe.
// ---------------------------------------------------------------------------
module grid_brush_stamp_isolate (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  gbs_pkg::req_type req_data,
   output logic             rsp_valid,
   output gbs_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [3:0]       csr_wdata
);

   gbs_pkg::cmd_type cmd;
   gbs_pkg::sts_type sts;
   logic             rsp_valid_ff;

   // sequencer: drives the datapath one column step at a time
   gbs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // map memory, brush and sweep logic, result register
   gbs_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

   // strobe the response in the cycle after the transaction finishes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/gbs_ctrl.sv @@
// ---------------------------------------------------------------------------
// gbs_ctrl
// Sequencer: read one cell, or stamp columns one by one, then sweep the interior columns.
// ---------------------------------------------------------------------------
`include "grid_brush_stamp_isolate_macros.svh"

module gbs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  gbs_pkg::sts_type sts,
   output gbs_pkg::cmd_type cmd
);

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_LAUNCH   = 8'b0000_0010,
      S_READ     = 8'b0000_0100,
      S_STAMP_RD = 8'b0000_1000,
      S_STAMP_WR = 8'b0001_0000,
      S_SWEEP_RD = 8'b0010_0000,
      S_SWEEP_SH = 8'b0100_0000,
      S_SWEEP_WR = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = S_LAUNCH;
            end
         end
         S_LAUNCH: begin
            if (sts.op_read) begin
               cmd.mem_rd = 1'b1;
               cmd.rd_req = 1'b1;
               state_in   = S_READ;
            end else begin
               cmd.cnt_stamp_init = 1'b1;
               state_in           = S_STAMP_RD;
            end
         end
         S_READ: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         S_STAMP_RD: begin
            cmd.mem_rd  = 1'b1;
            cmd.stamp_h = 1'b1;
            state_in    = S_STAMP_WR;
         end
         S_STAMP_WR: begin
            cmd.stamp_wr = 1'b1;
            if (sts.last_stamp) begin
               cmd.cnt_sweep_init = 1'b1;
               state_in           = S_SWEEP_RD;
            end else begin
               cmd.cnt_inc = 1'b1;
               state_in    = S_STAMP_RD;
            end
         end
         S_SWEEP_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_SWEEP_SH;
         end
         S_SWEEP_SH: begin
            cmd.sweep_sh = 1'b1;
            if (sts.sweep_ready) begin
               state_in = S_SWEEP_WR;
            end else begin
               cmd.cnt_inc = 1'b1;
               state_in    = S_SWEEP_RD;
            end
         end
         S_SWEEP_WR: begin
            cmd.sweep_wr = 1'b1;
            if (sts.last_sweep) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end else begin
               cmd.cnt_inc = 1'b1;
               state_in    = S_SWEEP_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `GBS_ASSERT_NEXT(a_accept_launch, clock, reset, cmd.accept, state_ff == S_LAUNCH, "accept must launch")
   `GBS_ASSERT_IMPLY(a_sweep_window, clock, reset, cmd.sweep_wr, sts.sweep_ready, "sweep write without full window")
   `GBS_ASSERT_NEXT(a_finish_idle, clock, reset, cmd.finish, !busy, "finish must return to idle")

endmodule

@@ rtl/gbs_datapath.sv @@
// ---------------------------------------------------------------------------
// gbs_datapath
// Column-wide map memory, brush mask, three-column sweep window, result reg.
// ---------------------------------------------------------------------------
module gbs_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  gbs_pkg::cmd_type      cmd,
   output gbs_pkg::sts_type      sts,
   input  gbs_pkg::req_type      req_data,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [3:0]            csr_wdata,
   output gbs_pkg::rsp_type      rsp_data
);

   localparam int CW = gbs_pkg::COL_W;
   localparam int WW = gbs_pkg::WORD_W;

   // one word per column, two bits per row
   logic [WW-1:0]         mem_ff [gbs_pkg::GRID_X];
   logic [gbs_pkg::GRID_X-1:0] valid_ff;
   logic [WW-1:0]         mem_q_ff;
   logic                  valid_q_ff;
   logic [CW-1:0]         rd_addr_ff;

   gbs_pkg::req_type      req_ff;
   gbs_pkg::rsp_type      rsp_ff;
   logic [3:0]            radius_ff;
   logic                  shape_ff;
   logic [CW-1:0]         cnt_ff;
   logic [3:0]            half_ff;
   logic [WW-1:0]         w0_ff, w1_ff, w2_ff;

   logic [CW-1:0]         rd_addr, wr_addr;
   logic                  wr_en;
   logic [WW-1:0]         wr_data, mem_word, stamp_word, sweep_word;
   logic [CW:0]           x_lo, x_hi;
   logic [6:0]            dx;
   logic [3:0]            adx;
   logic [7:0]            r_sq, a_sq;
   logic signed [8:0]     rem;
   logic [3:0]            half_in;
   logic signed [7:0]     y_lo, y_hi;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 4'd2;
         shape_ff  <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            gbs_pkg::CSR_RADIUS: radius_ff <= csr_wdata;
            gbs_pkg::CSR_SHAPE:  shape_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_data;
      end
   end

   // clipped column range of the brush
   always_comb begin
      x_lo = ({1'b0, req_ff.x_pos} > (CW+1)'(radius_ff)) ?
             ({1'b0, req_ff.x_pos} - (CW+1)'(radius_ff)) : '0;
      x_hi = {1'b0, req_ff.x_pos} + (CW+1)'(radius_ff);
      if (x_hi > (CW+1)'(gbs_pkg::GRID_X - 1)) begin
         x_hi = (CW+1)'(gbs_pkg::GRID_X - 1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cnt_stamp_init) begin
         cnt_ff <= x_lo[CW-1:0];
      end else if (cmd.cnt_sweep_init) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_inc) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign sts.op_read     = (req_ff.op == gbs_pkg::OP_READ);
   assign sts.last_stamp  = (cnt_ff == x_hi[CW-1:0]);
   assign sts.last_sweep  = (cnt_ff == CW'(gbs_pkg::GRID_X - 1));
   assign sts.sweep_ready = (cnt_ff >= CW'(2));

   // half height of the brush in the current column
   always_comb begin
      dx   = {1'b0, cnt_ff} - {1'b0, req_ff.x_pos};
      adx  = dx[6] ? 4'(-dx) : dx[3:0];
      r_sq = radius_ff * radius_ff;
      a_sq = adx * adx;
      rem  = $signed({1'b0, r_sq}) - $signed({1'b0, a_sq});
      if (shape_ff) begin
         half_in = '0;
         for (int k = 1; k < 16; k++) begin
            if (rem >= 9'(k * k)) begin
               half_in = 4'(k);
            end
         end
      end else begin
         half_in = radius_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.stamp_h) begin
         half_ff <= half_in;
      end
   end

   // memory port
   assign rd_addr = cmd.rd_req ? req_ff.x_pos : cnt_ff;

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         mem_q_ff   <= mem_ff[rd_addr];
         valid_q_ff <= valid_ff[rd_addr];
         rd_addr_ff <= rd_addr;
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign mem_word = valid_q_ff ? mem_q_ff : gbs_pkg::col_reset(rd_addr_ff);

   // stamp: replace rows inside [cy-h, cy+h]
   always_comb begin
      y_lo = $signed({2'b00, req_ff.y_pos}) - $signed({4'b0000, half_ff});
      y_hi = $signed({2'b00, req_ff.y_pos}) + $signed({4'b0000, half_ff});
      stamp_word = mem_word;
      for (int y = 0; y < gbs_pkg::GRID_Y; y++) begin
         if ($signed(8'(y)) >= y_lo && $signed(8'(y)) <= y_hi) begin
            stamp_word[2*y +: 2] = req_ff.cell_kind;
         end
      end
   end

   // sweep window: w0 = left, w1 = center, w2 = right
   always_ff @(posedge clock) begin
      if (cmd.sweep_sh) begin
         w0_ff <= w1_ff;
         w1_ff <= w2_ff;
         w2_ff <= mem_word;
      end
   end

   always_comb begin
      logic enclosed;
      sweep_word = w1_ff;
      for (int y = 1; y < gbs_pkg::GRID_Y - 1; y++) begin
         enclosed = (w0_ff[2*(y-1) +: 2] != gbs_pkg::KIND_LIQUID) &&
                    (w0_ff[2*y     +: 2] != gbs_pkg::KIND_LIQUID) &&
                    (w0_ff[2*(y+1) +: 2] != gbs_pkg::KIND_LIQUID) &&
                    (w1_ff[2*(y-1) +: 2] != gbs_pkg::KIND_LIQUID) &&
                    (w1_ff[2*(y+1) +: 2] != gbs_pkg::KIND_LIQUID) &&
                    (w2_ff[2*(y-1) +: 2] != gbs_pkg::KIND_LIQUID) &&
                    (w2_ff[2*y     +: 2] != gbs_pkg::KIND_LIQUID) &&
                    (w2_ff[2*(y+1) +: 2] != gbs_pkg::KIND_LIQUID);
         if (enclosed) begin
            sweep_word[2*y +: 2] = gbs_pkg::KIND_ISOLATED;
         end else if (w1_ff[2*y +: 2] == gbs_pkg::KIND_ISOLATED) begin
            sweep_word[2*y +: 2] = gbs_pkg::KIND_SOLID;
         end
      end
   end

   assign wr_en   = cmd.stamp_wr || cmd.sweep_wr;
   assign wr_addr = cmd.sweep_wr ? (cnt_ff - 1'b1) : cnt_ff;
   assign wr_data = cmd.sweep_wr ? sweep_word : stamp_word;

   // result register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff.done_res  <= 1'b1;
         rsp_ff.read_kind <= sts.op_read ? mem_word[2*req_ff.y_pos +: 2]
                                         : gbs_pkg::KIND_LIQUID;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

@@ verif/grid_brush_stamp_isolate_tb.sv @@
// ---------------------------------------------------------------------------
// grid_brush_stamp_isolate_tb
// Drives stamp and read transactions into the brush stamp block and compares
// each response with a behavioral copy of the map. The copy applies the
// clipped square or disc brush and then the interior isolation sweep.
// ---------------------------------------------------------------------------
module grid_brush_stamp_isolate_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   gbs_pkg::req_type req_data = '0;
   logic             rsp_valid;
   gbs_pkg::rsp_type rsp_data;
   logic       csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [3:0] csr_wdata = '0;

   grid_brush_stamp_isolate u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow map and shadow registers.
   logic [1:0] shadow_map [gbs_pkg::GRID_X][gbs_pkg::GRID_Y];
   logic [3:0] shadow_radius;
   logic       shadow_shape;

   gbs_pkg::req_type pending_reqs [$];
   gbs_pkg::rsp_type expected_rsps [$];
   int      error_count = 0;
   int      idle_cycles = 0;
   bit      quiet_phase = 1'b0;
   int      gap_left = 0;

   function automatic void shadow_reset();
      for (int x = 0; x < gbs_pkg::GRID_X; x++) begin
         for (int y = 0; y < gbs_pkg::GRID_Y; y++) begin
            shadow_map[x][y] = (x == 0 || x == gbs_pkg::GRID_X - 1 ||
                                y == 0 || y == gbs_pkg::GRID_Y - 1)
                               ? gbs_pkg::KIND_ABSORBER : gbs_pkg::KIND_LIQUID;
         end
      end
      shadow_radius = 4'd2;
      shadow_shape  = 1'b1;
   endfunction

   // Mark enclosed interior cells in place; a liquid cell with no liquid neighbour is marked too.
   function automatic void sweep_enclosed();
      bit walled;
      for (int x = 1; x < gbs_pkg::GRID_X - 1; x++) begin
         for (int y = 1; y < gbs_pkg::GRID_Y - 1; y++) begin
            walled = 1'b1;
            for (int dx = -1; dx <= 1; dx++) begin
               for (int dy = -1; dy <= 1; dy++) begin
                  if ((dx != 0 || dy != 0) &&
                      shadow_map[x+dx][y+dy] == gbs_pkg::KIND_LIQUID) begin
                     walled = 1'b0;
                  end
               end
            end
            if (walled) begin
               shadow_map[x][y] = gbs_pkg::KIND_ISOLATED;
            end else if (shadow_map[x][y] == gbs_pkg::KIND_ISOLATED) begin
               shadow_map[x][y] = gbs_pkg::KIND_SOLID;
            end
         end
      end
   endfunction

   function automatic gbs_pkg::rsp_type predict_cell_op(input gbs_pkg::req_type r);
      gbs_pkg::rsp_type res;
      int rad;
      int cx;
      int cy;
      res = '0;
      res.done_res = 1'b1;
      rad = int'(shadow_radius);
      cx = int'(r.x_pos);
      cy = int'(r.y_pos);
      if (r.op == gbs_pkg::OP_STAMP) begin
         for (int ix = cx - rad; ix <= cx + rad; ix++) begin
            for (int iy = cy - rad; iy <= cy + rad; iy++) begin
               if (ix >= 0 && ix < gbs_pkg::GRID_X && iy >= 0 && iy < gbs_pkg::GRID_Y &&
                   (!shadow_shape ||
                    (ix-cx)*(ix-cx) + (iy-cy)*(iy-cy) <= rad*rad)) begin
                  shadow_map[ix][iy] = r.cell_kind;
               end
            end
         end
         sweep_enclosed();
      end else begin
         res.read_kind = shadow_map[cx][cy];
      end
      return res;
   endfunction

   function automatic gbs_pkg::req_type make_req(input logic op, input int x, input int y,
                                                 input logic [1:0] kind);
      gbs_pkg::req_type r;
      r.op = op;
      r.x_pos = x[5:0];
      r.y_pos = y[5:0];
      r.cell_kind = kind;
      return r;
   endfunction

   // Mostly well-placed stamps with reads near them so the sweep shows.
   function automatic gbs_pkg::req_type random_req();
      gbs_pkg::req_type r;
      r.op = ($urandom_range(0, 9) < 4) ? gbs_pkg::OP_STAMP : gbs_pkg::OP_READ;
      r.x_pos = 6'($urandom_range(0, 63));
      r.y_pos = 6'($urandom_range(0, 63));
      if ($urandom_range(0, 3) != 0) begin
         r.x_pos = 6'($urandom_range(20, 43));
         r.y_pos = 6'($urandom_range(20, 43));
      end
      r.cell_kind = 2'($urandom_range(0, 3));
      return r;
   endfunction

   // Append one transaction to the driver's queue.
   function automatic void enqueue(input gbs_pkg::req_type r);
      pending_reqs.insert(pending_reqs.size(), r);
   endfunction

   // Driver: hold start until accepted, insert random gaps.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         void'(pending_reqs.pop_front());
         if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            gap_left <= $urandom_range(1, 16);
            start <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_data <= pending_reqs[0];
         end else begin
            start <= 1'b0;
         end
      end else if (!start) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
         end else if (pending_reqs.size() > 0) begin
            req_data <= pending_reqs[0];
            start <= 1'b1;
         end
      end
   end

   // Predict at accept so the shadow map tracks the order of transactions.
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         expected_rsps.insert(expected_rsps.size(), predict_cell_op(req_data));
      end
   end

   // Monitor: compare each response strobe with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response %p", $time, rsp_data);
            error_count++;
         end else begin
            if (rsp_data !== expected_rsps[0]) begin
               $display("%0t: mismatch expected %p actual %p",
                        $time, expected_rsps[0], rsp_data);
               error_count++;
            end
            void'(expected_rsps.pop_front());
         end
      end
   end

   // Watchdog: count cycles with no accepted transaction and no response.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("grid_brush_stamp_isolate_tb: FAIL");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || start || expected_rsps.size() > 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [3:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == gbs_pkg::CSR_RADIUS) begin
         shadow_radius = val;
      end else if (idx == gbs_pkg::CSR_SHAPE) begin
         shadow_shape = val[0];
      end
   endtask

   initial begin
      shadow_reset();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset map: corners, border, interior.
      enqueue(make_req(gbs_pkg::OP_READ, 0, 0, gbs_pkg::KIND_ISOLATED));
      enqueue(make_req(gbs_pkg::OP_READ, 63, 63, gbs_pkg::KIND_LIQUID));
      enqueue(make_req(gbs_pkg::OP_READ, 32, 0, gbs_pkg::KIND_LIQUID));
      enqueue(make_req(gbs_pkg::OP_READ, 1, 1, gbs_pkg::KIND_LIQUID));
      // Disc of radius 2 whose middle the sweep isolates.
      enqueue(make_req(gbs_pkg::OP_STAMP, 10, 10, gbs_pkg::KIND_SOLID));
      enqueue(make_req(gbs_pkg::OP_READ, 10, 10, gbs_pkg::KIND_LIQUID));
      enqueue(make_req(gbs_pkg::OP_READ, 12, 12, gbs_pkg::KIND_LIQUID));
      // Clipped brushes at corners; isolated solid stamped on the border.
      enqueue(make_req(gbs_pkg::OP_STAMP, 0, 0, gbs_pkg::KIND_ISOLATED));
      enqueue(make_req(gbs_pkg::OP_READ, 0, 1, gbs_pkg::KIND_LIQUID));
      enqueue(make_req(gbs_pkg::OP_READ, 1, 1, gbs_pkg::KIND_LIQUID));
      enqueue(make_req(gbs_pkg::OP_STAMP, 63, 63, gbs_pkg::KIND_ABSORBER));
      enqueue(make_req(gbs_pkg::OP_READ, 62, 62, gbs_pkg::KIND_LIQUID));
      // Liquid stamp breaks the enclosure.
      enqueue(make_req(gbs_pkg::OP_STAMP, 11, 10, gbs_pkg::KIND_LIQUID));
      enqueue(make_req(gbs_pkg::OP_READ, 10, 10, gbs_pkg::KIND_LIQUID));
      wait_drained();

      // Square brush at the largest radius.
      write_csr(gbs_pkg::CSR_SHAPE, 4'd0);
      write_csr(gbs_pkg::CSR_RADIUS, 4'd15);
      enqueue(make_req(gbs_pkg::OP_STAMP, 32, 32, gbs_pkg::KIND_SOLID));
      enqueue(make_req(gbs_pkg::OP_READ, 32, 32, gbs_pkg::KIND_LIQUID));
      enqueue(make_req(gbs_pkg::OP_READ, 47, 47, gbs_pkg::KIND_LIQUID));
      enqueue(make_req(gbs_pkg::OP_STAMP, 63, 0, gbs_pkg::KIND_ABSORBER));
      enqueue(make_req(gbs_pkg::OP_READ, 50, 10, gbs_pkg::KIND_LIQUID));
      wait_drained();

      // Radius zero with the square brush; out-of-range index is ignored.
      write_csr(gbs_pkg::CSR_RADIUS, 4'd0);
      write_csr(CSR_UNUSED, 4'd9);
      enqueue(make_req(gbs_pkg::OP_STAMP, 5, 5, gbs_pkg::KIND_LIQUID));
      enqueue(make_req(gbs_pkg::OP_READ, 5, 5, gbs_pkg::KIND_LIQUID));
      for (int i = 0; i < 30; i++) enqueue(random_req());
      wait_drained();

      // Random phases across register settings; last phase runs without gaps.
      for (int phase = 0; phase < 4; phase++) begin
         write_csr(gbs_pkg::CSR_SHAPE, 4'($urandom_range(0, 1)));
         write_csr(gbs_pkg::CSR_RADIUS,
                   (phase == 1) ? 4'd15 : 4'($urandom_range(0, 6)));
         quiet_phase = (phase == 3);
         for (int i = 0; i < 20; i++) enqueue(random_req());
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("grid_brush_stamp_isolate_tb: PASS");
      end else begin
         $display("grid_brush_stamp_isolate_tb: FAIL");
      end
      $finish;
   end

endmodule

@@ grid_brush_stamp_isolate.f @@
+incdir+rtl
rtl/gbs_pkg.sv
rtl/gbs_ctrl.sv
rtl/gbs_datapath.sv
rtl/grid_brush_stamp_isolate.sv
verif/grid_brush_stamp_isolate_tb.sv
